FILE: sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and codes for the banker's safety checker: item formats,
// action and status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // Input actions
  typedef enum logic [2:0] {
    ACT_LOAD_ALLOC = 3'd0,
    ACT_LOAD_MAX   = 3'd1,
    ACT_LOAD_AVAIL = 3'd2,
    ACT_CHECK      = 3'd3,
    ACT_REQUEST    = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [2:0] {
    RES_SEQ_ENTRY = 3'd0,
    RES_SAFE      = 3'd1,
    RES_UNSAFE    = 3'd2,
    RES_EXCEEDS   = 3'd3,
    RES_WAIT      = 3'd4
  } status_e;

  // Configuration register indexes
  localparam logic CFG_NUM_PROCESSES = 1'b0;
  localparam logic CFG_NUM_RESOURCES = 1'b1;

  localparam int unsigned CfgDataWidth = 5;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  process_index;
    logic [2:0]  resource_index;
    logic [15:0] amount;
    logic        final_element;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] sequence_process;
    logic       last_result;
  } out_item_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_REQ_RD,
    S_REQ_EV,
    S_REQ_WAIT,
    S_GRANT_RD,
    S_GRANT_WR,
    S_INIT,
    S_PROC,
    S_CHK_RD,
    S_CHK_EV,
    S_ADD_RD,
    S_ADD_EV,
    S_BACK_RD,
    S_BACK_WR,
    S_EMIT_SEQ,
    S_EMIT_ONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       ld_en;
    logic       rd_en;
    logic       work_init;
    logic       work_add;
    logic       fin_set;
    logic       avail_take;
    logic       avail_give;
    logic       alloc_add;
    logic       alloc_sub;
    logic       push;
    logic       push_seq;
    logic       push_last;
    logic [2:0] push_status;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_gt_work;
    logic req_gt_need;
    logic req_gt_avail;
    logic fin_hit;
    logic can_push;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/bsc_datapath.sv
// ----------------------------------------------------------------------------
// bsc_datapath
// Allocation and max-claim tables, available/request/work vectors, finished
// flags, safe sequence store and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_datapath #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned MAX_RESOURCES = 8,
  parameter int unsigned COUNT_WIDTH   = 16,
  parameter int unsigned PW = $clog2(MAX_PROCESSES),
  parameter int unsigned RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
  parameter int unsigned MW = $clog2(MAX_RESOURCES + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bsc_pkg::in_item_t   in_item_i,
  input  bsc_pkg::ctrl_cmd_t  cmd_i,
  input  wire  [PW-1:0]       proc_i,
  input  wire  [RW-1:0]       res_i,
  input  wire  [PW-1:0]       slot_i,
  input  wire  [MW-1:0]       m_act_i,
  output bsc_pkg::dp_stat_t   stat_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output bsc_pkg::out_item_t  out_item_o
);
  import bsc_pkg::*;

  localparam int unsigned WW    = COUNT_WIDTH + 4;
  localparam int unsigned AW    = PW + RW;
  localparam int unsigned Depth = MAX_PROCESSES << RW;

  logic [COUNT_WIDTH-1:0] alloc_mem [Depth];
  logic [COUNT_WIDTH-1:0] max_mem   [Depth];
  logic [COUNT_WIDTH-1:0] alloc_rd_q, max_rd_q;
  logic [COUNT_WIDTH-1:0] avail_q [MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0] req_q   [MAX_RESOURCES];
  logic [WW-1:0]          work_q  [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] fin_q;
  logic [PW-1:0]          seq_q   [MAX_PROCESSES];
  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   pin, rin;
  logic [COUNT_WIDTH-1:0] amt;
  logic [AW-1:0]          ld_addr, op_addr;
  logic                   ld_alloc, ld_max, ld_avail, ld_req;
  logic signed [COUNT_WIDTH:0] need;
  logic [WW:0]            work_sum;
  logic                   any_gt_avail;

  // Decode load beats
  assign pin      = 32'(in_item_i.process_index) < MAX_PROCESSES;
  assign rin      = 32'(in_item_i.resource_index) < MAX_RESOURCES;
  assign amt      = COUNT_WIDTH'(in_item_i.amount);
  assign ld_addr  = {PW'(in_item_i.process_index), RW'(in_item_i.resource_index)};
  assign op_addr  = {proc_i, res_i};
  assign ld_alloc = cmd_i.ld_en && in_item_i.action == ACT_LOAD_ALLOC && pin && rin;
  assign ld_max   = cmd_i.ld_en && in_item_i.action == ACT_LOAD_MAX && pin && rin;
  assign ld_avail = cmd_i.ld_en && in_item_i.action == ACT_LOAD_AVAIL && rin;
  assign ld_req   = cmd_i.ld_en && in_item_i.action == ACT_REQUEST && rin;

  // Allocation table: one write port shared by loads, grant and rollback
  always_ff @(posedge clk_i) begin
    if (ld_alloc) begin
      alloc_mem[ld_addr] <= amt;
    end else if (cmd_i.alloc_add) begin
      alloc_mem[op_addr] <= alloc_rd_q + req_q[res_i];
    end else if (cmd_i.alloc_sub) begin
      alloc_mem[op_addr] <= alloc_rd_q - req_q[res_i];
    end
    if (cmd_i.rd_en) begin
      alloc_rd_q <= alloc_mem[op_addr];
    end
  end

  // Max-claim table
  always_ff @(posedge clk_i) begin
    if (ld_max) begin
      max_mem[ld_addr] <= amt;
    end
    if (cmd_i.rd_en) begin
      max_rd_q <= max_mem[op_addr];
    end
  end

  // Available and request vectors
  always_ff @(posedge clk_i) begin
    if (ld_avail) begin
      avail_q[RW'(in_item_i.resource_index)] <= amt;
    end
    if (ld_req) begin
      req_q[RW'(in_item_i.resource_index)] <= amt;
    end
    for (int x = 0; x < MAX_RESOURCES; x++) begin
      if (x < int'(m_act_i)) begin
        if (cmd_i.avail_take) begin
          avail_q[x] <= avail_q[x] - req_q[x];
        end else if (cmd_i.avail_give) begin
          avail_q[x] <= avail_q[x] + req_q[x];
        end
      end
    end
  end

  // Signed need against work and request
  assign need     = $signed({1'b0, max_rd_q}) - $signed({1'b0, alloc_rd_q});
  assign work_sum = {1'b0, work_q[res_i]} + (WW+1)'(alloc_rd_q);

  always_comb begin
    any_gt_avail = 1'b0;
    for (int x = 0; x < MAX_RESOURCES; x++) begin
      if (x < int'(m_act_i) && req_q[x] > avail_q[x]) begin
        any_gt_avail = 1'b1;
      end
    end
  end

  // Work vector and finished flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int x = 0; x < MAX_RESOURCES; x++) begin
        work_q[x] <= '0;
      end
      fin_q <= '0;
    end else if (cmd_i.work_init) begin
      for (int x = 0; x < MAX_RESOURCES; x++) begin
        work_q[x] <= (x < int'(m_act_i)) ? WW'(avail_q[x]) : '0;
      end
      fin_q <= '0;
    end else begin
      if (cmd_i.work_add) begin
        work_q[res_i] <= work_sum[WW] ? '1 : work_sum[WW-1:0];
      end
      if (cmd_i.fin_set) begin
        fin_q[proc_i] <= 1'b1;
      end
    end
  end

  // Safe sequence store
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_set) begin
      seq_q[slot_i] <= proc_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.status           <= cmd_i.push_status;
      out_q.sequence_process <= cmd_i.push_seq ? 4'(seq_q[slot_i]) : 4'd0;
      out_q.last_result      <= cmd_i.push_last;
    end
  end

  assign stat_o.need_gt_work = !need[COUNT_WIDTH] &&
                               (WW'(need[COUNT_WIDTH-1:0]) > work_q[res_i]);
  assign stat_o.req_gt_need  = $signed({1'b0, req_q[res_i]}) > need;
  assign stat_o.req_gt_avail = any_gt_avail;
  assign stat_o.fin_hit      = fin_q[proc_i];
  assign stat_o.can_push     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer for loads, request evaluation, grant/rollback and the safety
// test passes, plus result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_ctrl #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned MAX_RESOURCES = 8,
  parameter int unsigned PW = $clog2(MAX_PROCESSES),
  parameter int unsigned NW = $clog2(MAX_PROCESSES + 1),
  parameter int unsigned RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
  parameter int unsigned MW = $clog2(MAX_RESOURCES + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  bsc_pkg::in_item_t   in_item_i,
  input  wire  [NW-1:0]       n_act_i,
  input  wire  [MW-1:0]       m_act_i,
  input  bsc_pkg::dp_stat_t   stat_i,
  output bsc_pkg::ctrl_cmd_t  cmd_o,
  output logic [PW-1:0]       proc_o,
  output logic [RW-1:0]       res_o,
  output logic [PW-1:0]       slot_o
);
  import bsc_pkg::*;

  state_e        state_q, state_d;
  logic [NW-1:0] i_q, i_d, cnt_q, cnt_d, k_q, k_d;
  logic [RW-1:0] j_q, j_d;
  logic [PW-1:0] p_q, p_d;
  logic [2:0]    end_q, end_d;
  logic          took_q, took_d, is_req_q, is_req_d;
  logic          j_last, accept;

  assign j_last = MW'(j_q) == (m_act_i - MW'(1));
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      j_q      <= '0;
      p_q      <= '0;
      end_q    <= RES_SAFE;
      took_q   <= 1'b0;
      is_req_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      j_q      <= j_d;
      p_q      <= p_d;
      end_q    <= end_d;
      took_q   <= took_d;
      is_req_q <= is_req_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    j_d      = j_q;
    p_d      = p_q;
    end_d    = end_q;
    took_d   = took_q;
    is_req_d = is_req_q;
    cmd_o    = '0;
    cmd_o.ld_en = accept;
    in_ready_o  = 1'b0;
    proc_o   = i_q[PW-1:0];
    res_o    = j_q;
    slot_o   = k_q[PW-1:0];

    case (state_q)
      // Take loads; start a check or a request evaluation
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          j_d = '0;
          if (in_item_i.action == ACT_CHECK) begin
            is_req_d = 1'b0;
            state_d  = S_INIT;
          end else if (in_item_i.action == ACT_REQUEST && in_item_i.final_element) begin
            is_req_d = 1'b1;
            p_d      = PW'(in_item_i.process_index);
            if ((NW > 4 ? NW : 4)'(in_item_i.process_index) >=
                (NW > 4 ? NW : 4)'(n_act_i)) begin
              end_d   = RES_EXCEEDS;
              state_d = S_EMIT_ONE;
            end else begin
              state_d = S_REQ_RD;
            end
          end
        end
      end
      // Request against remaining claim, one resource at a time
      S_REQ_RD: begin
        proc_o      = p_q;
        cmd_o.rd_en = 1'b1;
        state_d     = S_REQ_EV;
      end
      S_REQ_EV: begin
        proc_o = p_q;
        if (stat_i.req_gt_need) begin
          end_d   = RES_EXCEEDS;
          state_d = S_EMIT_ONE;
        end else if (j_last) begin
          state_d = S_REQ_WAIT;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_REQ_RD;
        end
      end
      // Request against available; grant tentatively
      S_REQ_WAIT: begin
        if (stat_i.req_gt_avail) begin
          end_d   = RES_WAIT;
          state_d = S_EMIT_ONE;
        end else begin
          cmd_o.avail_take = 1'b1;
          j_d     = '0;
          state_d = S_GRANT_RD;
        end
      end
      S_GRANT_RD: begin
        proc_o      = p_q;
        cmd_o.rd_en = 1'b1;
        state_d     = S_GRANT_WR;
      end
      S_GRANT_WR: begin
        proc_o          = p_q;
        cmd_o.alloc_add = 1'b1;
        if (j_last) begin
          state_d = S_INIT;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_GRANT_RD;
        end
      end
      // Load work from available, clear finished flags
      S_INIT: begin
        cmd_o.work_init = 1'b1;
        i_d     = '0;
        cnt_d   = '0;
        took_d  = 1'b0;
        state_d = S_PROC;
      end
      // Pick the next unfinished process or close the pass
      S_PROC: begin
        j_d = '0;
        if (cnt_q == n_act_i) begin
          k_d     = '0;
          state_d = S_EMIT_SEQ;
        end else if (i_q == n_act_i) begin
          if (!took_q) begin
            if (is_req_q) begin
              cmd_o.avail_give = 1'b1;
              state_d = S_BACK_RD;
            end else begin
              end_d   = RES_UNSAFE;
              state_d = S_EMIT_ONE;
            end
          end else begin
            i_d    = '0;
            took_d = 1'b0;
          end
        end else if (stat_i.fin_hit) begin
          i_d = i_q + NW'(1);
        end else begin
          state_d = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHK_EV;
      end
      S_CHK_EV: begin
        if (stat_i.need_gt_work) begin
          i_d     = i_q + NW'(1);
          state_d = S_PROC;
        end else if (j_last) begin
          j_d     = '0;
          state_d = S_ADD_RD;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_CHK_RD;
        end
      end
      // Release the process's allocation into work
      S_ADD_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_ADD_EV;
      end
      S_ADD_EV: begin
        cmd_o.work_add = 1'b1;
        slot_o         = cnt_q[PW-1:0];
        if (j_last) begin
          cmd_o.fin_set = 1'b1;
          cnt_d   = cnt_q + NW'(1);
          i_d     = i_q + NW'(1);
          took_d  = 1'b1;
          state_d = S_PROC;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_ADD_RD;
        end
      end
      // Undo an unsafe grant
      S_BACK_RD: begin
        proc_o      = p_q;
        cmd_o.rd_en = 1'b1;
        state_d     = S_BACK_WR;
      end
      S_BACK_WR: begin
        proc_o          = p_q;
        cmd_o.alloc_sub = 1'b1;
        if (j_last) begin
          end_d   = RES_UNSAFE;
          state_d = S_EMIT_ONE;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_BACK_RD;
        end
      end
      // Emit the safe sequence, one beat per process
      S_EMIT_SEQ: begin
        if (stat_i.can_push) begin
          cmd_o.push        = 1'b1;
          cmd_o.push_seq    = 1'b1;
          cmd_o.push_status = RES_SEQ_ENTRY;
          if (k_q == n_act_i - NW'(1)) begin
            end_d   = RES_SAFE;
            state_d = S_EMIT_ONE;
          end else begin
            k_d = k_q + NW'(1);
          end
        end
      end
      // Emit the closing status
      S_EMIT_ONE: begin
        if (stat_i.can_push) begin
          cmd_o.push        = 1'b1;
          cmd_o.push_last   = 1'b1;
          cmd_o.push_status = end_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bankers_safety_checker_top.sv
// ----------------------------------------------------------------------------
// bankers_safety_checker_top
// Banker's algorithm engine: table loads, safety check and request handling.
// ----------------------------------------------------------------------------
// Loads are accepted while the block is idle. A check or a final request beat
// holds the input side busy until its last result beat is registered. The
// allocation and max-claim tables sit in one single-port memory pair with
// registered read, so each table element takes a read state and a use state:
// a request tests each resource against its remaining claim, then all of them
// against available at once, then writes each allocation for the tentative
// grant; the safety test compares each resource per process comparison, adds
// each resource per released process and skips finished processes, over up to
// n passes of n processes, then emits n+1 result beats at one per cycle when
// the sink is ready. An unsafe grant is rolled back before the unsafe status.
`default_nettype none

module bankers_safety_checker_top #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned MAX_RESOURCES = 8,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_idx_i,
  input  wire  [bsc_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  bsc_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output bsc_pkg::out_item_t  out_item_o
);
  import bsc_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PROCESSES);
  localparam int unsigned NW = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int unsigned MW = $clog2(MAX_RESOURCES + 1);

  logic [4:0]    num_proc_q;
  logic [3:0]    num_res_q;
  logic [NW-1:0] n_act;
  logic [MW-1:0] m_act;
  ctrl_cmd_t     cmd;
  dp_stat_t      stat;
  logic [PW-1:0] proc, slot;
  logic [RW-1:0] res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_proc_q <= 5'd16;
      num_res_q  <= 4'd8;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM_PROCESSES) begin
        num_proc_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_NUM_RESOURCES) begin
        num_res_q <= cfg_data_i[3:0];
      end
    end
  end

  // Clamp counts into the supported range
  assign n_act = (num_proc_q == 5'd0) ? NW'(1) :
                 (32'(num_proc_q) > MAX_PROCESSES) ? NW'(MAX_PROCESSES) : NW'(num_proc_q);
  assign m_act = (num_res_q == 4'd0) ? MW'(1) :
                 (32'(num_res_q) > MAX_RESOURCES) ? MW'(MAX_RESOURCES) : MW'(num_res_q);

  bsc_ctrl #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .n_act_i    (n_act),
    .m_act_i    (m_act),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .proc_o     (proc),
    .res_o      (res),
    .slot_o     (slot)
  );

  bsc_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .proc_i      (proc),
    .res_i       (res),
    .slot_i      (slot),
    .m_act_i     (m_act),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A check beat always makes the block busy on the next cycle
  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.action == ACT_CHECK |=> !in_ready_o)
    else $error("check beat did not start the safety test");

  // Only sequence entries may be non-final beats
  a_seq_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_result |-> out_item_o.status == RES_SEQ_ENTRY)
    else $error("non-final beat carries a closing status");

  // Closing statuses carry no process
  a_status_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != RES_SEQ_ENTRY |->
      out_item_o.sequence_process == 4'd0 && out_item_o.last_result)
    else $error("closing beat malformed");

endmodule

`default_nettype wire
